>>> rtl/core/register_file_alu_assert.svh
// assertion macros shared by the register file alu checker
// no dependencies; included by the files that hold assertions
`ifndef REGISTER_FILE_ALU_ASSERT_SVH
`define REGISTER_FILE_ALU_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register file alu: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register file alu: next-cycle check failed");

`endif

>>> rtl/core/rfa_pkg.sv
// shared types, constants and helpers for the register file alu
// no dependencies; imported by every module of the block but rfa_ram
package rfa_pkg;

    // register file size and derived address width
    localparam int NUM_REGISTERS = 8;
    localparam int ADDR_W        = $clog2(NUM_REGISTERS);

    // field widths fixed by the instruction format
    localparam int OP_W   = 3;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_CMOV  = 3'd0,
        OP_ADD   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NAND  = 3'd4,
        OP_LOADI = 3'd5
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  dest_index;
        logic [IDX_W-1:0]  src_b_index;
        logic [IDX_W-1:0]  src_c_index;
        logic [DATA_W-1:0] immediate;
    } instr_t;

    typedef struct packed {
        logic              write_done;
        logic [IDX_W-1:0]  written_index;
        logic [DATA_W-1:0] written_value;
        logic              divide_by_zero;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic divisor_zero;
        logic div_last;
    } status_t;

    // index lies inside the register file
    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return int'(idx) < NUM_REGISTERS;
    endfunction

endpackage

>>> rtl/core/rfa_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> rtl/core/rfa_ctrl.sv
// controller state machine for the register file alu
// depends on rfa_pkg
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.is_div && !status.divisor_zero)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_FETCH:
            begin
                cmd.read = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/rfa_datapath.sv
// datapath: register file, operand capture, alu, serial divider, result register
// depends on rfa_pkg and rfa_ram
module rfa_datapath
    import rfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  instr_t  instr,
    input  cmd_t    cmd,
    output status_t status,
    output logic    done,
    output result_t result
);

    instr_t              instr_reg;
    logic                b_ok_reg;
    logic                c_ok_reg;
    logic [DATA_W-1:0]   alu_reg;
    logic                wr_reg;
    logic                dz_reg;
    logic [DATA_W-1:0]   quot_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_REGISTERS-1:0] valid_reg;
    logic                done_reg;
    result_t             result_reg;

    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [ADDR_W-1:0]   addr_c;
    logic [DATA_W-1:0]   rdata_b;
    logic [DATA_W-1:0]   rdata_c;
    logic [DATA_W-1:0]   rb;
    logic [DATA_W-1:0]   rc;
    logic [DATA_W-1:0]   alu_value;
    logic                alu_wr;
    logic                alu_dz;
    logic [DATA_W-1:0]   final_value;
    logic                ram_we;
    logic [DATA_W:0]     rem_shift;
    logic                rem_ge;

    assign addr_a = ADDR_W'(instr_reg.dest_index);
    assign addr_b = ADDR_W'(instr_reg.src_b_index);
    assign addr_c = ADDR_W'(instr_reg.src_c_index);

    // register file storage
    rfa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGISTERS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (addr_a),
        .wdata   (final_value),
        .re      (cmd.read),
        .raddr_a (addr_b),
        .raddr_b (addr_c),
        .rdata_a (rdata_b),
        .rdata_b (rdata_c)
    );

    // instruction capture on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            instr_reg <= instr;
        end
    end

    // operand qualifiers: out of range or never written reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            b_ok_reg <= in_range(instr_reg.src_b_index) && valid_reg[addr_b];
            c_ok_reg <= in_range(instr_reg.src_c_index) && valid_reg[addr_c];
        end
    end

    assign rb = b_ok_reg ? rdata_b : '0;
    assign rc = c_ok_reg ? rdata_c : '0;

    // alu for the non-divide ops, plus the divide write and zero-divisor flags
    always_comb
    begin
        alu_value = '0;
        alu_wr    = 1'b0;
        alu_dz    = 1'b0;
        unique case (op_t'(instr_reg.op))
            OP_CMOV:
            begin
                alu_wr    = (rc != '0);
                alu_value = rb;
            end
            OP_ADD:
            begin
                alu_wr    = 1'b1;
                alu_value = rb + rc;
            end
            OP_MUL:
            begin
                alu_wr    = 1'b1;
                alu_value = rb * rc;
            end
            OP_DIV:
            begin
                alu_wr = (rc != '0);
                alu_dz = (rc == '0);
            end
            OP_NAND:
            begin
                alu_wr    = 1'b1;
                alu_value = ~(rb & rc);
            end
            OP_LOADI:
            begin
                alu_wr    = 1'b1;
                alu_value = instr_reg.immediate;
            end
            default:
            begin
                alu_wr = 1'b0;
            end
        endcase
    end

    // execute stage registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            alu_reg <= alu_value;
            wr_reg  <= alu_wr && in_range(instr_reg.dest_index);
            dz_reg  <= alu_dz;
        end
    end

    // restoring divider step
    assign rem_shift = {rem_reg, quot_reg[DATA_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            quot_reg <= rb;
            rem_reg  <= '0;
            div_reg  <= rc;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[DATA_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? DATA_W'(rem_shift - {1'b0, div_reg})
                               : rem_shift[DATA_W-1:0];
        end
    end

    // divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign status.is_div       = (op_t'(instr_reg.op) == OP_DIV);
    assign status.divisor_zero = (rc == '0);
    assign status.div_last     = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // write back
    assign final_value = status.is_div ? quot_reg : alu_reg;
    assign ram_we      = cmd.finish && wr_reg;

    // per-entry valid bits stand in for the cleared register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[addr_a] <= 1'b1;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.write_done     <= wr_reg;
            result_reg.written_index  <= wr_reg ? instr_reg.dest_index : '0;
            result_reg.written_value  <= wr_reg ? final_value : '0;
            result_reg.divide_by_zero <= dz_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/register_file_alu.sv
// register file alu: eight 32-bit registers with cmov/add/mul/div/nand/loadi
// an instruction steps through fetch, execute and finish; a divide with a nonzero divisor adds the serial divide state
// between execute and finish; a new instruction is taken only while idle, and busy is high in every other state
// results are strobed on done for one cycle; the receiver cannot stall
// reset clears every register at once through per-entry valid bits, no clearing pass
// depends on rfa_pkg, rfa_ctrl, rfa_datapath
module register_file_alu
    import rfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  instr_t  instr,
    output logic    done,
    output result_t result
);

    cmd_t    cmd;
    status_t status;

    // control
    rfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // datapath
    rfa_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

>>> rtl/core/rfa_checker.sv
// port-level checker for the register file alu, bound to the top level
// depends on rfa_pkg and register_file_alu_assert.svh
`include "register_file_alu_assert.svh"

module rfa_checker
    import rfa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    logic accept;
    logic write_fields_zero;

    assign accept            = start && !busy;
    assign write_fields_zero = (result.written_index == '0) && (result.written_value == '0);

    // an accepted transaction keeps the block busy
    `RFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)

    // the result strobe comes exactly when busy drops
    `RFA_ASSERT_IMPLY(a_fell_done, clk, rst_n, $fell(busy), done)

    // no result while still busy
    `RFA_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)

    // a result without a write carries zeros in the write fields
    `RFA_ASSERT_IMPLY(a_no_write_zero, clk, rst_n, done && !result.write_done, write_fields_zero)

endmodule

bind register_file_alu rfa_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> sim/register_file_alu_tb.sv
// self-checking testbench for the register file alu
// predicts every write from its own copy of the registers and checks each strobed result
// depends on rfa_pkg and register_file_alu
module register_file_alu_tb;
    import rfa_pkg::*;

    // op codes the block leaves unused, each must give an all-zero result
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // items per random phase and cycles to linger after the last result
    localparam int PHASE_ITEMS  = 567;
    localparam int SETTLE_TICKS = 50;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    instr_t  instr = '0;
    logic    done;
    result_t result;

    // instructions waiting to be driven and writes waiting to be observed
    instr_t  instr_queue[$];
    result_t write_queue[$];

    // predictor copy of the register file
    logic [DATA_W-1:0] regs[NUM_REGISTERS];

    int      idle_pct = 24;
    int      error_count = 0;
    int      accepted_count = 0;
    int      result_count = 0;
    int      write_count = 0;
    int      zero_div_count = 0;
    result_t want;

    register_file_alu DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .instr  (instr),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("timeout with %0d results still outstanding", write_queue.size());
        $display("Mismatches found");
        $finish;
    end

    // compute the write of one instruction and update the register copy
    function automatic result_t compute_write(instr_t ins);
        logic [DATA_W-1:0] rb;
        logic [DATA_W-1:0] rc;
        logic [DATA_W-1:0] val;
        logic              wr;
        logic              dz;
        result_t           r;
        rb  = (int'(ins.src_b_index) < NUM_REGISTERS) ? regs[ins.src_b_index] : '0;
        rc  = (int'(ins.src_c_index) < NUM_REGISTERS) ? regs[ins.src_c_index] : '0;
        val = '0;
        wr  = 1'b0;
        dz  = 1'b0;
        case (ins.op)
            OP_CMOV:
            begin
                if (rc != '0)
                begin
                    wr  = 1'b1;
                    val = rb;
                end
            end
            OP_ADD:
            begin
                wr  = 1'b1;
                val = rb + rc;
            end
            OP_MUL:
            begin
                wr  = 1'b1;
                val = rb * rc;
            end
            OP_DIV:
            begin
                if (rc == '0)
                    dz = 1'b1;
                else
                begin
                    wr  = 1'b1;
                    val = rb / rc;
                end
            end
            OP_NAND:
            begin
                wr  = 1'b1;
                val = ~(rb & rc);
            end
            OP_LOADI:
            begin
                wr  = 1'b1;
                val = ins.immediate;
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
        // a destination past the end of the file discards the write
        if (wr && int'(ins.dest_index) >= NUM_REGISTERS)
            wr = 1'b0;
        r = '0;
        if (wr)
        begin
            regs[ins.dest_index] = val;
            r.write_done    = 1'b1;
            r.written_index = ins.dest_index;
            r.written_value = val;
        end
        r.divide_by_zero = dz;
        return r;
    endfunction

    // random instruction, weighted toward loads so the file holds live data
    function automatic instr_t random_instr();
        instr_t ins;
        int     pick;
        ins.dest_index  = 3'($urandom_range(0, 7));
        ins.src_b_index = 3'($urandom_range(0, 7));
        ins.src_c_index = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 24)
            ins.op = OP_LOADI;
        else if (pick < 38)
            ins.op = OP_CMOV;
        else if (pick < 50)
            ins.op = OP_ADD;
        else if (pick < 62)
            ins.op = OP_MUL;
        else if (pick < 78)
            ins.op = OP_DIV;
        else if (pick < 94)
            ins.op = OP_NAND;
        else if (pick < 97)
            ins.op = OP_SPARE_6;
        else
            ins.op = OP_SPARE_7;
        // zeros and small values make zero divisors and false move conditions common
        case ($urandom_range(0, 5))
            0: ins.immediate = '0;
            1: ins.immediate = 32'd1;
            2: ins.immediate = '1;
            3: ins.immediate = 32'($urandom_range(0, 15));
            default: ins.immediate = $urandom;
        endcase
        return ins;
    endfunction

    task automatic push_instr(input logic [OP_W-1:0] op, input int a, input int b,
                              input int c, input logic [DATA_W-1:0] imm);
        instr_t ins;
        ins.op          = op;
        ins.dest_index  = 3'(a);
        ins.src_b_index = 3'(b);
        ins.src_c_index = 3'(c);
        ins.immediate   = imm;
        instr_queue.push_back(ins);
    endtask

    // sender holds off until every queued transaction has come back
    task automatic wait_drain();
        do
            @(negedge clk);
        while (instr_queue.size() != 0 || start || write_queue.size() != 0);
    endtask

    // driver: record accepted transactions, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            instr <= '0;
            for (int i = 0; i < NUM_REGISTERS; i++)
                regs[i] = '0;
        end
        else
        begin
            if (start && !busy)
            begin
                write_queue.push_back(compute_write(instr));
                accepted_count++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (instr_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                instr <= instr_queue.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count++;
            if (write_queue.size() == 0)
            begin
                $error("result with nothing expected: %p", result);
                error_count++;
            end
            else
            begin
                want = write_queue.pop_front();
                if (want.write_done) write_count++;
                if (want.divide_by_zero) zero_div_count++;
                if (result.write_done !== want.write_done)
                begin
                    $error("write_done expected %0b actual %0b",
                           want.write_done, result.write_done);
                    error_count++;
                end
                if (result.written_index !== want.written_index)
                begin
                    $error("written_index expected %0d actual %0d",
                           want.written_index, result.written_index);
                    error_count++;
                end
                if (result.written_value !== want.written_value)
                begin
                    $error("written_value expected %08h actual %08h",
                           want.written_value, result.written_value);
                    error_count++;
                end
                if (result.divide_by_zero !== want.divide_by_zero)
                begin
                    $error("divide_by_zero expected %0b actual %0b",
                           want.divide_by_zero, result.divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: operand extremes, wrapping, every op and the corner cases
        push_instr(OP_LOADI, 0, 0, 0, 32'hFFFF_FFFF);
        push_instr(OP_LOADI, 1, 5, 6, 32'h0000_0000);
        push_instr(OP_LOADI, 2, 7, 7, 32'h0000_0001);
        push_instr(OP_LOADI, 3, 0, 0, 32'h8000_0000);
        push_instr(OP_LOADI, 7, 0, 0, 32'h0000_0007);
        push_instr(OP_ADD, 4, 0, 2, '0);
        push_instr(OP_MUL, 5, 0, 0, '0);
        push_instr(OP_MUL, 6, 3, 3, '0);
        push_instr(OP_DIV, 6, 0, 7, '0);
        // zero divisor leaves the destination alone
        push_instr(OP_DIV, 5, 0, 1, '1);
        push_instr(OP_DIV, 4, 0, 0, '0);
        // move condition zero then nonzero
        push_instr(OP_CMOV, 2, 0, 1, '0);
        push_instr(OP_CMOV, 2, 0, 3, '0);
        push_instr(OP_NAND, 5, 0, 0, '0);
        push_instr(OP_NAND, 6, 1, 1, '0);
        push_instr(OP_ADD, 7, 0, 0, '0);
        // unused op codes, the first with every field set
        push_instr(OP_SPARE_6, 7, 7, 7, '1);
        push_instr(OP_SPARE_7, 3, 0, 2, 32'hA5A5_5A5A);
        push_instr(OP_DIV, 1, 1, 2, '0);
        push_instr(OP_LOADI, 7, 0, 0, '0);
        push_instr(OP_DIV, 3, 3, 7, '0);
        push_instr(OP_CMOV, 5, 0, 5, '0);
        push_instr(OP_ADD, 0, 3, 1, '0);
        wait_drain();

        // random phases: light sender idling, heavy idling, then back to back
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                instr_queue.push_back(random_instr());
            wait_drain();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (write_queue.size() != 0)
        begin
            $error("%0d predicted results never arrived", write_queue.size());
            error_count++;
        end

        $display("ran %0d instructions and checked %0d results", accepted_count, result_count);
        $display("%0d register writes, %0d divides by zero, %0d field errors",
                 write_count, zero_div_count, error_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
